FILE: rtl/assert_macros.svh
// Assertion helper macros for the lidar projection block.
// Used by the top level; expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge outside reset.
`define LPP_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition that must never be seen outside reset.
`define LPP_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

FILE: rtl/lpp_pkg.sv
// Shared types and constants for the lidar point projection pipeline.
// No dependencies; imported by every module of the block.
package lpp_pkg;

    localparam int ROT_W      = 16;  // Q2.14 rotation entry and 16-bit translation
    localparam int Q_FRAC     = 14;  // fraction bits of the rotation
    localparam int INTR_W     = 16;  // Q12.4 intrinsic entry
    localparam int FOCAL_FRAC = 4;   // fraction bits of the intrinsics
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int DIMS_W     = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_EXT_ROW0  = 3'd0,
        REG_EXT_ROW1  = 3'd1,
        REG_EXT_ROW2  = 3'd2,
        REG_INTRINSIC = 3'd3,
        REG_IMG_DIMS  = 3'd4
    } lpp_reg_t;

    // Per-axis projection status ahead of the divider
    typedef struct packed {
        logic neg;   // numerator negative
        logic ovf;   // quotient at or above 2^(PIXEL_BITS+1)
    } lpp_lane_t;

endpackage

FILE: rtl/lidar_point_to_pixel_projection.sv
// Throughput: one point per cycle unless m_axis_tready stalls the output; every stage is
// registered and the divider retires one quotient bit per stage in PIXEL_BITS+1 stages.
// Reset (rst_n, async, active low) clears all valid bits and config registers.
// Config writes are taken every cycle (cfg_ready is always high).
module lidar_point_to_pixel_projection
    import lpp_pkg::*;
#(
    parameter int COORD_BITS = 20,
    parameter int PIXEL_BITS = 12,
    localparam int IN_TW  = ((3*COORD_BITS + 7) / 8) * 8,
    localparam int OUT_TW = ((2*PIXEL_BITS + COORD_BITS + 7) / 8) * 8
)(
    input  logic                  clk,
    input  logic                  rst_n,
    // config write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // input point words
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_TW-1:0]      s_axis_tdata,   // point_x, point_y, point_z, zero pad
    // output pixel words
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_TW-1:0]     m_axis_tdata,   // pixel_col, pixel_row, cam_depth, zero pad
    output logic                  m_axis_tuser    // in_view
);

`include "assert_macros.svh"

    localparam int CW      = COORD_BITS + 5;
    localparam int MW      = COORD_BITS + INTR_W + 5;
    localparam int DW      = COORD_BITS + FOCAL_FRAC + 4;
    localparam int QW      = PIXEL_BITS + 1;
    localparam int DIMS_XW = (2*PIXEL_BITS > DIMS_W) ? 2*PIXEL_BITS : DIMS_W;

    // ---------------- config registers ----------------
    logic [CFG_DATA_W-1:0] ext_row_reg [3];
    logic [CFG_DATA_W-1:0] intr_reg;
    logic [DIMS_W-1:0]     dims_reg;
    logic [DIMS_XW-1:0]    dims_wide;
    logic [PIXEL_BITS-1:0] img_w, img_h;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ext_row_reg[0] <= '0;
            ext_row_reg[1] <= '0;
            ext_row_reg[2] <= '0;
            intr_reg       <= '0;
            dims_reg       <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_EXT_ROW0:  ext_row_reg[0] <= cfg_data;
                REG_EXT_ROW1:  ext_row_reg[1] <= cfg_data;
                REG_EXT_ROW2:  ext_row_reg[2] <= cfg_data;
                REG_INTRINSIC: intr_reg       <= cfg_data;
                REG_IMG_DIMS:  dims_reg       <= cfg_data[DIMS_W-1:0];
                default:       ;  // unmapped index, write dropped
            endcase
        end
    end

    // width in the low PIXEL_BITS bits, height right above
    assign dims_wide = DIMS_XW'(dims_reg);
    assign img_w     = dims_wide[PIXEL_BITS-1:0];
    assign img_h     = dims_wide[2*PIXEL_BITS-1:PIXEL_BITS];

    // ---------------- stage 1-2: extrinsic transform ----------------
    logic                  xf_valid, xf_ready;
    logic signed [CW-1:0]  cam_x, cam_y, cam_z;

    lpp_xform #(
        .COORD_BITS (COORD_BITS)
    ) u_xform (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .point_x   (s_axis_tdata[COORD_BITS-1:0]),
        .point_y   (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
        .point_z   (s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS]),
        .ext_row   (ext_row_reg),
        .out_valid (xf_valid),
        .out_ready (xf_ready),
        .cam_x     (cam_x),
        .cam_y     (cam_y),
        .cam_z     (cam_z)
    );

    // ---------------- stage 3-4: numerators, divisor, range flags ----------------
    logic                         su_valid, su_ready;
    logic [MW-1:0]                mag_x, mag_y;
    logic [DW-1:0]                den;
    lpp_lane_t                    su_lane_x, su_lane_y;
    logic                         su_z_pos;
    logic signed [COORD_BITS-1:0] su_depth;

    lpp_setup #(
        .COORD_BITS (COORD_BITS),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_setup (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (xf_valid),
        .in_ready   (xf_ready),
        .cam_x      (cam_x),
        .cam_y      (cam_y),
        .cam_z      (cam_z),
        .intrinsics (intr_reg),
        .out_valid  (su_valid),
        .out_ready  (su_ready),
        .mag_x      (mag_x),
        .mag_y      (mag_y),
        .den        (den),
        .lane_x     (su_lane_x),
        .lane_y     (su_lane_y),
        .z_pos      (su_z_pos),
        .depth      (su_depth)
    );

    // ---------------- divider: PIXEL_BITS+1 stages ----------------
    logic                         dv_valid, dv_ready;
    logic [QW-1:0]                quot_x, quot_y;
    lpp_lane_t                    dv_lane_x, dv_lane_y;
    logic                         dv_z_pos;
    logic signed [COORD_BITS-1:0] dv_depth;

    lpp_div #(
        .COORD_BITS (COORD_BITS),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (su_valid),
        .in_ready   (su_ready),
        .mag_x      (mag_x),
        .mag_y      (mag_y),
        .den        (den),
        .lane_x     (su_lane_x),
        .lane_y     (su_lane_y),
        .z_pos      (su_z_pos),
        .depth      (su_depth),
        .out_valid  (dv_valid),
        .out_ready  (dv_ready),
        .quot_x     (quot_x),
        .quot_y     (quot_y),
        .lane_x_out (dv_lane_x),
        .lane_y_out (dv_lane_y),
        .z_pos_out  (dv_z_pos),
        .depth_out  (dv_depth)
    );

    // ---------------- final stage: bounds check and output register ----------------
    // Truncating division: a negative numerator gives col 0 only when |num| < den,
    // i.e. the magnitude quotient is zero; anything else below zero is off image.
    // Pixel 0 still has to lie below the image size, so a zero size never passes.
    logic                         col_ok, row_ok, vis_next;
    logic [PIXEL_BITS-1:0]        col_next, row_next;
    logic                         out_valid_reg, in_view_reg;
    logic [PIXEL_BITS-1:0]        col_reg, row_reg;
    logic signed [COORD_BITS-1:0] depth_reg;
    logic                         out_en;

    assign out_en   = !out_valid_reg || m_axis_tready;
    assign dv_ready = out_en;

    always_comb
    begin
        col_ok   = !dv_lane_x.ovf && (!dv_lane_x.neg || (quot_x == '0)) &&
                   (quot_x < QW'(img_w));
        row_ok   = !dv_lane_y.ovf && (!dv_lane_y.neg || (quot_y == '0)) &&
                   (quot_y < QW'(img_h));
        vis_next = dv_z_pos && col_ok && row_ok;
        col_next = vis_next ? quot_x[PIXEL_BITS-1:0] : '0;
        row_next = vis_next ? quot_y[PIXEL_BITS-1:0] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_en)
        begin
            out_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_en)
        begin
            in_view_reg <= vis_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            depth_reg   <= dv_depth;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = in_view_reg;
    assign m_axis_tdata  = OUT_TW'({depth_reg, row_reg, col_reg});

    // ---------------- assertions ----------------
    `LPP_ASSERT_IMPL(a_view_in_bounds, m_axis_tvalid && in_view_reg,
        (col_reg < img_w) && (row_reg < img_h), "in-view pixel outside image")
    `LPP_ASSERT_IMPL(a_off_view_zero, m_axis_tvalid && !in_view_reg,
        (col_reg == '0) && (row_reg == '0), "off-view pixel not zeroed")
    `LPP_ASSERT_IMPL(a_view_depth_pos, m_axis_tvalid && in_view_reg,
        depth_reg > 0, "in-view point with non-positive depth")
    `LPP_ASSERT_NEVER(a_stall_cause, !s_axis_tready && !(m_axis_tvalid && !m_axis_tready),
        "input stalled without output backpressure")

endmodule

FILE: rtl/lpp_xform.sv
// Rigid transform stages: point times 3x4 extrinsic matrix, floored to mm.
// Two register stages; depends on lpp_pkg.
module lpp_xform
    import lpp_pkg::*;
#(
    parameter int COORD_BITS
)(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [COORD_BITS-1:0]        point_x,
    input  logic signed [COORD_BITS-1:0]        point_y,
    input  logic signed [COORD_BITS-1:0]        point_z,
    input  logic        [CFG_DATA_W-1:0]        ext_row [3],
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [COORD_BITS+4:0]        cam_x,
    output logic signed [COORD_BITS+4:0]        cam_y,
    output logic signed [COORD_BITS+4:0]        cam_z
);

    localparam int PW = COORD_BITS + ROT_W;
    localparam int AW = COORD_BITS + 19;
    localparam int CW = AW - Q_FRAC;

    logic signed [COORD_BITS-1:0] pt [3];
    logic signed [PW-1:0]         prod_reg [3][3];
    logic signed [PW-1:0]         prod_next [3][3];
    logic signed [ROT_W-1:0]      trans_reg [3];
    logic signed [ROT_W-1:0]      trans_next [3];
    logic signed [AW-1:0]         acc [3];
    logic signed [CW-1:0]         coord_reg [3];
    logic signed [CW-1:0]         coord_next [3];
    logic [1:0]                   v_reg;
    logic [2:0]                   en;

    assign pt[0] = point_x;
    assign pt[1] = point_y;
    assign pt[2] = point_z;

    assign en[2]     = out_ready;
    assign en[1]     = !v_reg[1] || en[2];
    assign en[0]     = !v_reg[0] || en[1];
    assign in_ready  = en[0];
    assign out_valid = v_reg[1];

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                prod_next[r][k] = $signed(ext_row[r][ROT_W*k +: ROT_W]) * pt[k];
            end
            trans_next[r] = $signed(ext_row[r][4*ROT_W-1 -: ROT_W]);
        end
    end

    // floor(acc / 2^14) is an arithmetic shift
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            acc[r] = AW'(prod_reg[r][0]) + AW'(prod_reg[r][1]) + AW'(prod_reg[r][2])
                   + (AW'(trans_reg[r]) <<< Q_FRAC);
            coord_next[r] = acc[r][AW-1:Q_FRAC];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= in_valid;
            end
            if (en[1])
            begin
                v_reg[1] <= v_reg[0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            prod_reg  <= prod_next;
            trans_reg <= trans_next;
        end
        if (en[1])
        begin
            coord_reg <= coord_next;
        end
    end

    assign cam_x = coord_reg[0];
    assign cam_y = coord_reg[1];
    assign cam_z = coord_reg[2];

endmodule

FILE: rtl/lpp_setup.sv
// Projection setup: numerators c*f + ctr*z, their magnitudes, the divisor 16*z,
// range checks and depth saturation. Two register stages; depends on lpp_pkg.
module lpp_setup
    import lpp_pkg::*;
#(
    parameter int COORD_BITS,
    parameter int PIXEL_BITS
)(
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      in_valid,
    output logic                                      in_ready,
    input  logic signed [COORD_BITS+4:0]              cam_x,
    input  logic signed [COORD_BITS+4:0]              cam_y,
    input  logic signed [COORD_BITS+4:0]              cam_z,
    input  logic        [CFG_DATA_W-1:0]              intrinsics,
    output logic                                      out_valid,
    input  logic                                      out_ready,
    output logic        [COORD_BITS+INTR_W+4:0]       mag_x,
    output logic        [COORD_BITS+INTR_W+4:0]       mag_y,
    output logic        [COORD_BITS+FOCAL_FRAC+3:0]   den,
    output lpp_lane_t                                 lane_x,
    output lpp_lane_t                                 lane_y,
    output logic                                      z_pos,
    output logic signed [COORD_BITS-1:0]              depth
);

    localparam int CW = COORD_BITS + 5;
    localparam int NW = CW + INTR_W + 1;
    localparam int MW = NW - 1;
    localparam int DW = CW - 1 + FOCAL_FRAC;

    logic signed [NW-1:0]         xf_reg, cxz_reg, yf_reg, cyz_reg;
    logic signed [CW-1:0]         zc_reg;
    logic signed [NW-1:0]         num_x, num_y, neg_num_x, neg_num_y;
    logic [MW-1:0]                mag_x_next, mag_y_next, mag_x_reg, mag_y_reg;
    logic [DW-1:0]                den_next, den_reg;
    lpp_lane_t                    lane_x_next, lane_y_next, lane_x_reg, lane_y_reg;
    logic                         z_pos_next, z_pos_reg;
    logic [CW-COORD_BITS:0]       z_hi;
    logic signed [COORD_BITS-1:0] depth_next, depth_reg;
    logic [1:0]                   v_reg;
    logic [2:0]                   en;

    assign en[2]     = out_ready;
    assign en[1]     = !v_reg[1] || en[2];
    assign en[0]     = !v_reg[0] || en[1];
    assign in_ready  = en[0];
    assign out_valid = v_reg[1];

    always_comb
    begin
        num_x      = xf_reg + cxz_reg;
        num_y      = yf_reg + cyz_reg;
        neg_num_x  = -num_x;
        neg_num_y  = -num_y;
        mag_x_next = num_x[NW-1] ? neg_num_x[MW-1:0] : num_x[MW-1:0];
        mag_y_next = num_y[NW-1] ? neg_num_y[MW-1:0] : num_y[MW-1:0];
        den_next   = {zc_reg[CW-2:0], {FOCAL_FRAC{1'b0}}};
        // quotient >= 2^(P+1) iff floor(mag / 2^(P+1)) >= den
        lane_x_next.neg = num_x[NW-1];
        lane_x_next.ovf = (mag_x_next >> (PIXEL_BITS + 1)) >= MW'(den_next);
        lane_y_next.neg = num_y[NW-1];
        lane_y_next.ovf = (mag_y_next >> (PIXEL_BITS + 1)) >= MW'(den_next);
        z_pos_next = !zc_reg[CW-1] && (zc_reg != '0);
        z_hi       = zc_reg[CW-1:COORD_BITS-1];
        if ((z_hi == '0) || (z_hi == '1))
        begin
            depth_next = zc_reg[COORD_BITS-1:0];
        end
        else if (zc_reg[CW-1])
        begin
            depth_next = {1'b1, {(COORD_BITS-1){1'b0}}};
        end
        else
        begin
            depth_next = {1'b0, {(COORD_BITS-1){1'b1}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= in_valid;
            end
            if (en[1])
            begin
                v_reg[1] <= v_reg[0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            xf_reg  <= cam_x * $signed({1'b0, intrinsics[INTR_W-1:0]});
            yf_reg  <= cam_y * $signed({1'b0, intrinsics[2*INTR_W-1:INTR_W]});
            cxz_reg <= cam_z * $signed({1'b0, intrinsics[3*INTR_W-1:2*INTR_W]});
            cyz_reg <= cam_z * $signed({1'b0, intrinsics[4*INTR_W-1:3*INTR_W]});
            zc_reg  <= cam_z;
        end
        if (en[1])
        begin
            mag_x_reg  <= mag_x_next;
            mag_y_reg  <= mag_y_next;
            den_reg    <= den_next;
            lane_x_reg <= lane_x_next;
            lane_y_reg <= lane_y_next;
            z_pos_reg  <= z_pos_next;
            depth_reg  <= depth_next;
        end
    end

    assign mag_x  = mag_x_reg;
    assign mag_y  = mag_y_reg;
    assign den    = den_reg;
    assign lane_x = lane_x_reg;
    assign lane_y = lane_y_reg;
    assign z_pos  = z_pos_reg;
    assign depth  = depth_reg;

endmodule

FILE: rtl/lpp_div.sv
// Pipelined restoring divider for column and row, one quotient bit per stage,
// PIXEL_BITS+1 stages sharing one divisor. Depends on lpp_pkg.
module lpp_div
    import lpp_pkg::*;
#(
    parameter int COORD_BITS,
    parameter int PIXEL_BITS
)(
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      in_valid,
    output logic                                      in_ready,
    input  logic        [COORD_BITS+INTR_W+4:0]       mag_x,
    input  logic        [COORD_BITS+INTR_W+4:0]       mag_y,
    input  logic        [COORD_BITS+FOCAL_FRAC+3:0]   den,
    input  lpp_lane_t                                 lane_x,
    input  lpp_lane_t                                 lane_y,
    input  logic                                      z_pos,
    input  logic signed [COORD_BITS-1:0]              depth,
    output logic                                      out_valid,
    input  logic                                      out_ready,
    output logic        [PIXEL_BITS:0]                quot_x,
    output logic        [PIXEL_BITS:0]                quot_y,
    output lpp_lane_t                                 lane_x_out,
    output lpp_lane_t                                 lane_y_out,
    output logic                                      z_pos_out,
    output logic signed [COORD_BITS-1:0]              depth_out
);

    localparam int MW = COORD_BITS + INTR_W + 5;
    localparam int DW = COORD_BITS + FOCAL_FRAC + 4;
    localparam int QW = PIXEL_BITS + 1;
    localparam int NS = PIXEL_BITS + 1;
    localparam int XW = (MW > DW + PIXEL_BITS) ? MW : DW + PIXEL_BITS;

    logic [MW-1:0]                rem_x_in [NS], rem_y_in [NS];
    logic [MW-1:0]                rem_x_reg [NS], rem_y_reg [NS];
    logic [QW-1:0]                q_x_in [NS], q_y_in [NS];
    logic [QW-1:0]                q_x_reg [NS], q_y_reg [NS];
    logic [DW-1:0]                den_in [NS], den_reg [NS];
    lpp_lane_t                    lx_in [NS], ly_in [NS], lx_reg [NS], ly_reg [NS];
    logic                         zp_in [NS], zp_reg [NS];
    logic signed [COORD_BITS-1:0] dep_in [NS], dep_reg [NS];
    logic                         v_in [NS];
    logic [NS-1:0]                v_reg;
    logic [NS:0]                  en;

    assign en[NS]    = out_ready;
    assign in_ready  = en[0];
    assign out_valid = v_reg[NS-1];

    for (genvar s = 0; s < NS; s++)
    begin : g_stage
        localparam int BIT = PIXEL_BITS - s;

        logic [XW-1:0] dsh;
        logic          ge_x, ge_y;
        logic [MW-1:0] rem_x_next, rem_y_next;
        logic [QW-1:0] q_x_next, q_y_next;

        if (s == 0)
        begin : g_head
            assign rem_x_in[s] = mag_x;
            assign rem_y_in[s] = mag_y;
            assign q_x_in[s]   = '0;
            assign q_y_in[s]   = '0;
            assign den_in[s]   = den;
            assign lx_in[s]    = lane_x;
            assign ly_in[s]    = lane_y;
            assign zp_in[s]    = z_pos;
            assign dep_in[s]   = depth;
            assign v_in[s]     = in_valid;
        end
        else
        begin : g_body
            assign rem_x_in[s] = rem_x_reg[s-1];
            assign rem_y_in[s] = rem_y_reg[s-1];
            assign q_x_in[s]   = q_x_reg[s-1];
            assign q_y_in[s]   = q_y_reg[s-1];
            assign den_in[s]   = den_reg[s-1];
            assign lx_in[s]    = lx_reg[s-1];
            assign ly_in[s]    = ly_reg[s-1];
            assign zp_in[s]    = zp_reg[s-1];
            assign dep_in[s]   = dep_reg[s-1];
            assign v_in[s]     = v_reg[s-1];
        end

        assign en[s] = !v_reg[s] || en[s+1];

        always_comb
        begin
            dsh        = XW'(den_in[s]) << BIT;
            ge_x       = XW'(rem_x_in[s]) >= dsh;
            ge_y       = XW'(rem_y_in[s]) >= dsh;
            rem_x_next = ge_x ? MW'(XW'(rem_x_in[s]) - dsh) : rem_x_in[s];
            rem_y_next = ge_y ? MW'(XW'(rem_y_in[s]) - dsh) : rem_y_in[s];
            q_x_next   = q_x_in[s] | (QW'(ge_x) << BIT);
            q_y_next   = q_y_in[s] | (QW'(ge_y) << BIT);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[s] <= 1'b0;
            end
            else if (en[s])
            begin
                v_reg[s] <= v_in[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[s])
            begin
                rem_x_reg[s] <= rem_x_next;
                rem_y_reg[s] <= rem_y_next;
                q_x_reg[s]   <= q_x_next;
                q_y_reg[s]   <= q_y_next;
                den_reg[s]   <= den_in[s];
                lx_reg[s]    <= lx_in[s];
                ly_reg[s]    <= ly_in[s];
                zp_reg[s]    <= zp_in[s];
                dep_reg[s]   <= dep_in[s];
            end
        end
    end

    assign quot_x     = q_x_reg[NS-1];
    assign quot_y     = q_y_reg[NS-1];
    assign lane_x_out = lx_reg[NS-1];
    assign lane_y_out = ly_reg[NS-1];
    assign z_pos_out  = zp_reg[NS-1];
    assign depth_out  = dep_reg[NS-1];

endmodule

FILE: verif/lidar_point_to_pixel_projection_tb.sv
// Self-checking bench for lidar_point_to_pixel_projection: directed and random points.
// An in-bench model predicts each pixel word and a small scoreboard checks the results.
// Depends on lpp_pkg and the block's RTL only.
module lidar_point_to_pixel_projection_tb;
    import lpp_pkg::*;

    localparam int COORD_W  = 20;
    localparam int PIX_W    = 12;
    localparam int IN_W     = 64;   // 3*20 bits, zero padded to 8 bytes
    localparam int OUT_W    = 48;   // 12+12+20 bits, zero padded to 6 bytes
    localparam int PIPE_LAT = 18;   // pipeline latency of the block at default sizes

    typedef logic [COORD_W-1:0] coord_t;

    // One pixel word as the block sends it
    typedef struct packed {
        logic               in_view;
        logic [PIX_W-1:0]   col;
        logic [PIX_W-1:0]   row;
        logic [COORD_W-1:0] depth;
    } pixel_t;

    // Holds a copy of the register file, predicts the pixel word of each point
    // and compares the words that come out, oldest first.
    class pixel_scoreboard;
        logic [CFG_DATA_W-1:0] ext_row [3];
        logic [CFG_DATA_W-1:0] intr;
        logic [DIMS_W-1:0]     dims;
        pixel_t                pixels_due [$];
        int                    fails;

        function new();
            foreach (ext_row[k])
                ext_row[k] = '0;
            intr  = '0;
            dims  = '0;
            fails = 0;
        endfunction

        function void write_reg(lpp_reg_t idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_EXT_ROW0:  ext_row[0] = val;
                REG_EXT_ROW1:  ext_row[1] = val;
                REG_EXT_ROW2:  ext_row[2] = val;
                REG_INTRINSIC: intr = val;
                REG_IMG_DIMS:  dims = val[DIMS_W-1:0];
                default:       ;
            endcase
        endfunction

        // One row of the rigid transform, floored to whole mm (Q2.14 rotation)
        function longint cam_axis(logic [CFG_DATA_W-1:0] r, longint px, longint py,
                                  longint pz);
            longint acc;
            acc = longint'($signed(r[15:0])) * px + longint'($signed(r[31:16])) * py
                + longint'($signed(r[47:32])) * pz + (longint'($signed(r[63:48])) <<< Q_FRAC);
            return acc >>> Q_FRAC;
        endfunction

        function void note_point(coord_t x, coord_t y, coord_t z);
            longint px, py, pz, xc, yc, zc, col, row, wid, hgt;
            pixel_t want;
            px   = longint'($signed(x));
            py   = longint'($signed(y));
            pz   = longint'($signed(z));
            xc   = cam_axis(ext_row[0], px, py, pz);
            yc   = cam_axis(ext_row[1], px, py, pz);
            zc   = cam_axis(ext_row[2], px, py, pz);
            wid  = longint'(dims[PIX_W-1:0]);
            hgt  = longint'(dims[2*PIX_W-1:PIX_W]);
            want = '0;
            // depth saturates; projection uses the unsaturated coordinates
            if (zc > 524287)
                want.depth = 20'h7FFFF;
            else if (zc < -524288)
                want.depth = 20'h80000;
            else
                want.depth = zc[COORD_W-1:0];
            if (zc > 0)
            begin
                // division truncates toward zero, so -0.5 px lands on pixel 0
                col = (xc * longint'(intr[15:0]) + longint'(intr[47:32]) * zc) / (16 * zc);
                row = (yc * longint'(intr[31:16]) + longint'(intr[63:48]) * zc) / (16 * zc);
                if (col >= 0 && col < wid && row >= 0 && row < hgt)
                begin
                    want.in_view = 1'b1;
                    want.col     = col[PIX_W-1:0];
                    want.row     = row[PIX_W-1:0];
                end
            end
            pixels_due = {pixels_due, want};
        endfunction

        function void check_pixel(logic user, logic [OUT_W-1:0] data);
            pixel_t got, want;
            got.in_view = user;
            got.col     = data[PIX_W-1:0];
            got.row     = data[2*PIX_W-1:PIX_W];
            got.depth   = data[2*PIX_W+COORD_W-1:2*PIX_W];
            if (pixels_due.size() == 0)
            begin
                $error("pixel word with no point outstanding: %h", data);
                fails++;
                return;
            end
            want = pixels_due.pop_front();
            if (got.in_view !== want.in_view)
            begin
                $error("in_view: expected %0d, got %0d", want.in_view, got.in_view);
                fails++;
            end
            if (got.col !== want.col)
            begin
                $error("pixel_col: expected %0d, got %0d", want.col, got.col);
                fails++;
            end
            if (got.row !== want.row)
            begin
                $error("pixel_row: expected %0d, got %0d", want.row, got.row);
                fails++;
            end
            if (got.depth !== want.depth)
            begin
                $error("cam_depth: expected %0d, got %0d",
                       $signed(want.depth), $signed(got.depth));
                fails++;
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_W-1:0]       s_axis_tdata;   // point_x, point_y, point_z, zero pad
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_W-1:0]      m_axis_tdata;   // pixel_col, pixel_row, cam_depth, zero pad
    logic                  m_axis_tuser;   // in_view

    // idle controls, changed with nonblocking writes so the edge sampling is clean
    logic src_idle;    // sender may insert gaps
    logic sink_idle;   // receiver may drop tready in bursts
    logic sink_hold;   // receiver holds tready low for a long stretch

    pixel_scoreboard sb = new();

    lidar_point_to_pixel_projection u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #10 clk = ~clk;

    // Register writes: valid stays up across a batch, the caller drops it after.
    task automatic write_cfg(input lpp_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.write_reg(idx, val);
    endtask

    // Wait until every point has come back, then let the pipe run dry.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (sb.pixels_due.size() != 0)
            @(posedge clk);
        repeat (PIPE_LAT + 6) @(posedge clk);
    endtask

    // Writes the whole register file, only with the block idle.
    task automatic set_config(input logic [CFG_DATA_W-1:0] row0, input logic [CFG_DATA_W-1:0] row1,
                              input logic [CFG_DATA_W-1:0] row2, input logic [CFG_DATA_W-1:0] intr,
                              input logic [DIMS_W-1:0] dims);
        settle();
        write_cfg(REG_EXT_ROW0, row0);
        write_cfg(REG_EXT_ROW1, row1);
        write_cfg(REG_EXT_ROW2, row2);
        write_cfg(REG_INTRINSIC, intr);
        write_cfg(REG_IMG_DIMS, {{(CFG_DATA_W-DIMS_W){1'b0}}, dims});
        cfg_valid <= 1'b0;
    endtask

    // One point word; tvalid stays high into the next call unless a gap is drawn.
    task automatic send_point(input coord_t x, input coord_t y, input coord_t z);
        int gap;
        if (src_idle && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 10);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, z, y, x};
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_point(x, y, z);
    endtask

    // Point in front of a near-identity camera: |x|,|y| up to z/2, packed {z, y, x}
    function automatic logic [3*COORD_W-1:0] front_point();
        int zr;
        zr = $urandom_range(200, 100000);
        return {20'(zr), 20'(int'($urandom_range(0, zr)) - zr / 2),
                20'(int'($urandom_range(0, zr)) - zr / 2)};
    endfunction

    // Rotation row near a unit axis plus a small translation
    function automatic logic [CFG_DATA_W-1:0] near_axis(int axis);
        logic [15:0] e [3];
        for (int k = 0; k < 3; k++)
            e[k] = 16'(int'($urandom_range(0, 4000)) - 2000) + ((k == axis) ? 16'h4000 : 16'h0);
        return {16'(int'($urandom_range(0, 4000)) - 2000), e[2], e[1], e[0]};
    endfunction

    // Random phase: mostly a plausible camera with points in front of it, sometimes
    // fully random registers; the points are mostly in front, the rest anywhere.
    task automatic random_phase(input int count, input bit calm);
        int wid, hgt;
        logic [3*COORD_W-1:0] pt;
        wid = $urandom_range(16, 1920);
        hgt = $urandom_range(16, 1200);
        if ($urandom_range(0, 4) == 0)
            set_config({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                       {$urandom, $urandom}, 24'($urandom));
        else
            set_config(near_axis(0), near_axis(1), near_axis(2),
                       {16'(hgt * 8 + $urandom_range(0, 15)), 16'(wid * 8 + $urandom_range(0, 15)),
                        16'($urandom_range(1600, 48000)), 16'($urandom_range(1600, 48000))},
                       {12'(hgt), 12'(wid)});
        src_idle  <= !calm && $urandom_range(0, 3) != 0;
        sink_idle <= !calm && $urandom_range(0, 3) != 0;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 9) < 7)
                pt = front_point();
            else
                pt = {20'($urandom), 20'($urandom), 20'($urandom)};
            send_point(pt[19:0], pt[39:20], pt[59:40]);
        end
    endtask

    // Receiver: checks each accepted word, then decides tready for the next edge.
    initial
    begin : sink_proc
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
                sb.check_pixel(m_axis_tuser, m_axis_tdata);
            if (sink_hold)
                m_axis_tready <= 1'b0;
            else if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else if (sink_idle && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, 9);
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Stimulus
    initial
    begin : stim_proc
        logic [CFG_DATA_W-1:0] id_row0, id_row1, id_row2, cam_intr, sat_row;
        logic [DIMS_W-1:0]     vga_dims;
        logic [3*COORD_W-1:0]  pt;
        rst_n         <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_index     <= REG_EXT_ROW0;
        cfg_data      <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        m_axis_tready <= 1'b0;
        src_idle      <= 1'b0;
        sink_idle     <= 1'b0;
        sink_hold     <= 1'b0;
        // identity extrinsics, f = 500 px, centre (320, 240), 640x480 image
        id_row0  = {16'h0000, 16'h0000, 16'h0000, 16'h4000};
        id_row1  = {16'h0000, 16'h0000, 16'h4000, 16'h0000};
        id_row2  = {16'h0000, 16'h4000, 16'h0000, 16'h0000};
        cam_intr = {16'd3840, 16'd5120, 16'd8000, 16'd8000};
        vga_dims = {12'd480, 12'd640};
        sat_row  = {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // registers at reset: every depth floors to zero, nothing in view
        send_point(20'd0, 20'd0, 20'd1000);
        send_point(20'h7FFFF, 20'h80000, 20'h7FFFF);

        // plain camera: centre, image edges, truncation toward zero, depth sign
        set_config(id_row0, id_row1, id_row2, cam_intr, vga_dims);
        send_point(20'd0, 20'd0, 20'd1000);
        send_point(20'd639, 20'd0, 20'd1000);       // last column
        send_point(20'd640, 20'd0, 20'd1000);       // one past the right edge
        send_point(-20'sd641, 20'd0, 20'd1000);     // col -0.5 truncates to 0
        send_point(20'd0, 20'd479, 20'd1000);       // last row
        send_point(20'd0, 20'd480, 20'd1000);
        send_point(20'd0, -20'sd481, 20'd1000);     // row -0.5 truncates to 0
        send_point(20'd0, 20'd0, 20'd0);            // zero depth
        send_point(20'd0, 20'd0, -20'sd1000);       // behind the camera
        send_point(20'd0, 20'd0, 20'd1);
        send_point(20'h7FFFF, 20'h7FFFF, 20'h7FFFF);
        send_point(20'h80000, 20'h80000, 20'h80000);
        send_point(20'h80000, 20'd0, 20'h7FFFF);

        // half scale: a positive depth under 1 mm floors to zero
        set_config({48'h0, 16'h2000}, {32'h0, 16'h2000, 16'h0}, {16'h0, 16'h2000, 32'h0},
                   cam_intr, vga_dims);
        send_point(20'd0, 20'd0, 20'd1);
        send_point(20'd0, 20'd0, -20'sd1);
        send_point(20'd0, 20'd0, 20'd3);

        // largest gains: depth saturates both ways, largest intrinsics and image
        set_config({16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF}, sat_row, sat_row,
                   64'hFFFF_FFFF_FFFF_FFFF, 24'hFFFFFF);
        send_point(20'h7FFFF, 20'h7FFFF, 20'h7FFFF);
        send_point(20'h80000, 20'h80000, 20'h80000);
        send_point(20'd0, 20'd0, 20'd0);

        // zero width, then zero height: never in view
        set_config(id_row0, id_row1, id_row2, cam_intr, {12'd480, 12'd0});
        send_point(20'd0, 20'd0, 20'd1000);
        set_config(id_row0, id_row1, id_row2, cam_intr, {12'd0, 12'd640});
        send_point(20'd0, 20'd0, 20'd1000);

        // every register bit set
        set_config('1, '1, '1, '1, '1);
        send_point(20'd1000, 20'd1000, 20'd1000);
        send_point(20'h80000, 20'h80000, 20'h80000);

        // random phases with idling on both sides
        for (int p = 0; p < 5; p++)
            random_phase(80, 1'b0);

        // back pressure: receiver stops for a long stretch while points keep coming
        set_config(id_row0, id_row1, id_row2, cam_intr, vga_dims);
        src_idle  <= 1'b0;
        sink_idle <= 1'b0;
        fork
            begin
                sink_hold <= 1'b1;
                repeat (400) @(posedge clk);
                sink_hold <= 1'b0;
            end
            for (int i = 0; i < 60; i++)
            begin
                pt = front_point();
                send_point(pt[19:0], pt[39:20], pt[59:40]);
            end
        join

        random_phase(80, 1'b0);
        // closing part runs at full rate on both sides
        random_phase(80, 1'b1);
        random_phase(80, 1'b1);

        settle();
        if (sb.fails == 0 && sb.pixels_due.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Run limit, far beyond the slowest legal run
    initial
    begin
        #4000000;
        $display("tb: failure");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/lpp_pkg.sv
rtl/lpp_xform.sv
rtl/lpp_setup.sv
rtl/lpp_div.sv
rtl/lidar_point_to_pixel_projection.sv
verif/lidar_point_to_pixel_projection_tb.sv
